/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the max flow design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define MFEK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define MFEK_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define MFEK_ASSERT(lbl, clk, rstn, prop)
`define MFEK_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* design/mfek_pkg.sv */
// ----------------------------------------------------------------------------
// mfek_pkg
// shared constants, state type and controller/datapath command and status structs
// ----------------------------------------------------------------------------
package mfek_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int CAP_WIDTH_DEF = 16;

    // fixed field widths
    localparam int NODE_IN_W = 4;
    localparam int CAP_IN_W  = 16;
    localparam int TOTAL_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int NCOUNT_W  = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

    // register reset values
    localparam logic [NCOUNT_W-1:0]  NODE_COUNT_RST = 5'd16;
    localparam logic [NODE_IN_W-1:0] SOURCE_RST     = 4'd0;
    localparam logic [NODE_IN_W-1:0] SINK_RST       = 4'd15;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_SCAN,
        ST_DRAIN,
        ST_AUG,
        ST_AUG_RD,
        ST_AUG_W1,
        ST_AUG_W2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clear_wr;
        logic bfs_init;
        logic pop;
        logic issue;
        logic aug_start;
        logic aug_rd;
        logic aug_w1;
        logic aug_w2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic edge_last;
        logic bad_cfg;
        logic clear_done;
        logic queue_empty;
        logic found;
        logic scan_last;
        logic at_src;
        logic out_free;
    } t_status;

endpackage

/* design/mfek_ifs.sv */
// ----------------------------------------------------------------------------
// mfek_ifs
// valid/ready channels for edge input and flow result
// ----------------------------------------------------------------------------
interface mfek_edge_if;
    logic                               valid;
    logic                               ready;
    logic [mfek_pkg::NODE_IN_W-1:0]     from_node;
    logic [mfek_pkg::NODE_IN_W-1:0]     to_node;
    logic [mfek_pkg::CAP_IN_W-1:0]      edge_capacity;
    logic                               last_edge;

    modport source (output valid, from_node, to_node, edge_capacity, last_edge,
                    input ready);
    modport sink   (input valid, from_node, to_node, edge_capacity, last_edge,
                    output ready);
endinterface

interface mfek_flow_if;
    logic                               valid;
    logic                               ready;
    logic [mfek_pkg::TOTAL_W-1:0]       total_flow;

    modport source (output valid, total_flow, input ready);
    modport sink   (input valid, total_flow, output ready);
endinterface

/* design/mfek_ctrl.sv */
// ----------------------------------------------------------------------------
// mfek_ctrl
// sequencer: clear sweep, edge loading, bfs, augment and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfek_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfek_pkg::t_status  i_status,
    output mfek_pkg::t_cmd     o_cmd
);

    mfek_pkg::t_state r_state;
    mfek_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfek_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            mfek_pkg::ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_done) n_state = mfek_pkg::ST_LOAD;
            end
            mfek_pkg::ST_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.edge_last) begin
                    n_state = i_status.bad_cfg ? mfek_pkg::ST_EMIT : mfek_pkg::ST_INIT;
                end
            end
            mfek_pkg::ST_INIT: begin
                o_cmd.bfs_init = 1'b1;
                n_state        = mfek_pkg::ST_POP;
            end
            mfek_pkg::ST_POP: begin
                if (i_status.queue_empty) begin
                    n_state = mfek_pkg::ST_EMIT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = mfek_pkg::ST_SCAN;
                end
            end
            mfek_pkg::ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.found)          n_state = mfek_pkg::ST_AUG;
                else if (i_status.scan_last) n_state = mfek_pkg::ST_DRAIN;
            end
            mfek_pkg::ST_DRAIN: begin
                n_state = i_status.found ? mfek_pkg::ST_AUG : mfek_pkg::ST_POP;
            end
            mfek_pkg::ST_AUG: begin
                o_cmd.aug_start = 1'b1;
                n_state         = mfek_pkg::ST_AUG_RD;
            end
            mfek_pkg::ST_AUG_RD: begin
                if (i_status.at_src) begin
                    n_state = mfek_pkg::ST_INIT;
                end else begin
                    o_cmd.aug_rd = 1'b1;
                    n_state      = mfek_pkg::ST_AUG_W1;
                end
            end
            mfek_pkg::ST_AUG_W1: begin
                o_cmd.aug_w1 = 1'b1;
                n_state      = mfek_pkg::ST_AUG_W2;
            end
            mfek_pkg::ST_AUG_W2: begin
                o_cmd.aug_w2 = 1'b1;
                n_state      = mfek_pkg::ST_AUG_RD;
            end
            mfek_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mfek_pkg::ST_CLEAR;
                end
            end
            default: begin
                n_state = mfek_pkg::ST_CLEAR;
            end
        endcase
    end

    `MFEK_ASSERT(a_found_only_scanning, i_clk, i_rst_n, i_status.found |-> (r_state == mfek_pkg::ST_SCAN || r_state == mfek_pkg::ST_DRAIN))

endmodule

/* design/mfek_dp.sv */
// ----------------------------------------------------------------------------
// mfek_dp
// datapath: capacity/flow memories, bfs queue, parents, flow sum, result reg
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfek_dp #(
    parameter int MAX_NODES = mfek_pkg::MAX_NODES_DEF,
    parameter int CAP_WIDTH = mfek_pkg::CAP_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfek_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mfek_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    mfek_edge_if.sink                         i_edge,
    mfek_flow_if.source                       o_result,
    input  mfek_pkg::t_cmd                    i_cmd,
    output mfek_pkg::t_status                 o_status
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = 2 * NODE_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int FLOW_W = CAP_WIDTH + 1;
    localparam int RES_W  = CAP_WIDTH + 2;
    localparam int BN_W   = CAP_WIDTH + 1;
    localparam int SUM_W  = ((mfek_pkg::TOTAL_W > BN_W) ? mfek_pkg::TOTAL_W : BN_W) + 1;
    localparam logic [BN_W-1:0]              BN_INF    = {BN_W{1'b1}};
    localparam logic [mfek_pkg::TOTAL_W-1:0] TOTAL_MAX = {mfek_pkg::TOTAL_W{1'b1}};

    // configuration
    logic [mfek_pkg::NCOUNT_W-1:0]  r_node_count;
    logic [mfek_pkg::NODE_IN_W-1:0] r_src;
    logic [mfek_pkg::NODE_IN_W-1:0] r_dst;

    // memories
    logic [CAP_WIDTH-1:0]     r_cap_mem  [DEPTH];
    logic signed [FLOW_W-1:0] r_flow_mem [DEPTH];
    logic [CAP_WIDTH-1:0]     r_cap_q;
    logic signed [FLOW_W-1:0] r_flow_q;

    // search state
    logic [NODE_W-1:0]    r_q_node [MAX_NODES];
    logic [BN_W-1:0]      r_q_bn   [MAX_NODES];
    logic [NODE_W-1:0]    r_parent [MAX_NODES];
    logic [MAX_NODES-1:0] r_visited;
    logic [CNT_W-1:0]     r_head;
    logic [CNT_W-1:0]     r_tail;
    logic [NODE_W-1:0]    r_u;
    logic [BN_W-1:0]      r_f;
    logic [NODE_W-1:0]    r_v;
    logic [NODE_W-1:0]    r_v_d;
    logic                 r_eval;
    logic [BN_W-1:0]      r_nf;
    logic [NODE_W-1:0]    r_cur;
    logic [NODE_W-1:0]    r_par;
    logic [ADDR_W-1:0]    r_clr;
    logic [mfek_pkg::TOTAL_W-1:0] r_sum;
    logic                         r_out_valid;
    logic [mfek_pkg::TOTAL_W-1:0] r_out_total;

    logic [CNT_W-1:0]        n_live;
    logic                    bad_cfg;
    logic [NODE_W-1:0]       src_idx;
    logic [NODE_W-1:0]       dst_idx;
    logic                    edge_take;
    logic                    edge_in_range;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    rd_en;
    logic signed [RES_W-1:0] room;
    logic [BN_W-1:0]         room_u;
    logic                    room_pos;
    logic [BN_W-1:0]         nf;
    logic                    eval_hit;
    logic                    found;
    logic [SUM_W-1:0]        sum_ext;
    logic [NODE_W-1:0]       cur_parent;
    logic                    out_free;
    logic signed [RES_W-1:0] nf_s;
    logic [FLOW_W-1:0]       flow_inc;
    logic [FLOW_W-1:0]       flow_dec;

    // oversized node count acts as the full array
    assign n_live  = (32'(r_node_count) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                     : CNT_W'(r_node_count);
    assign bad_cfg = (32'(r_src) >= 32'(n_live)) || (32'(r_dst) >= 32'(n_live))
                     || (r_src == r_dst);
    assign src_idx = NODE_W'(r_src);
    assign dst_idx = NODE_W'(r_dst);

    assign edge_take     = i_edge.valid && i_cmd.in_ready;
    assign edge_in_range = (32'(i_edge.from_node) < 32'(n_live))
                           && (32'(i_edge.to_node) < 32'(n_live));
    assign i_edge.ready  = i_cmd.in_ready;

    assign cur_parent = r_parent[r_cur];

    always_comb begin
        rd_en   = i_cmd.issue || i_cmd.aug_rd || i_cmd.aug_w1;
        rd_addr = {r_u, r_v};
        if (i_cmd.aug_rd)      rd_addr = {cur_parent, r_cur};
        else if (i_cmd.aug_w1) rd_addr = {r_cur, r_par};
    end

    // residual of the edge read last cycle
    assign room     = $signed({2'b00, r_cap_q}) - RES_W'(r_flow_q);
    assign room_pos = !room[RES_W-1] && (room != '0);
    assign room_u   = BN_W'(room);
    assign nf       = (room_u < r_f) ? room_u : r_f;
    assign eval_hit = r_eval && !r_visited[r_v_d] && room_pos;
    assign found    = eval_hit && (r_v_d == dst_idx);

    assign sum_ext  = SUM_W'(r_sum) + SUM_W'(r_nf);
    assign out_free = !r_out_valid || o_result.ready;
    assign nf_s     = $signed({1'b0, r_nf});
    assign flow_inc = FLOW_W'(RES_W'(r_flow_q) + nf_s);
    assign flow_dec = FLOW_W'(RES_W'(r_flow_q) - nf_s);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= mfek_pkg::NODE_COUNT_RST;
            r_src        <= mfek_pkg::SOURCE_RST;
            r_dst        <= mfek_pkg::SINK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mfek_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                mfek_pkg::CFG_SOURCE:     r_src <= mfek_pkg::NODE_IN_W'(i_cfg_data);
                mfek_pkg::CFG_SINK:       r_dst <= mfek_pkg::NODE_IN_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // capacity and flow memories, one write and one read port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_cap_mem[r_clr]  <= '0;
            r_flow_mem[r_clr] <= '0;
        end else begin
            if (edge_take && edge_in_range) begin
                r_cap_mem[{NODE_W'(i_edge.from_node), NODE_W'(i_edge.to_node)}]
                    <= CAP_WIDTH'(i_edge.edge_capacity);
            end
            if (i_cmd.aug_w1) r_flow_mem[{r_par, r_cur}] <= flow_inc;
            if (i_cmd.aug_w2) r_flow_mem[{r_cur, r_par}] <= flow_dec;
        end
        if (rd_en) begin
            r_cap_q  <= r_cap_mem[rd_addr];
            r_flow_q <= r_flow_mem[rd_addr];
        end
    end

    // search payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.bfs_init) begin
            r_q_node[0] <= src_idx;
            r_q_bn[0]   <= BN_INF;
        end else if (eval_hit && !found && (32'(r_tail) < MAX_NODES)) begin
            r_q_node[r_tail[NODE_W-1:0]] <= r_v_d;
            r_q_bn[r_tail[NODE_W-1:0]]   <= nf;
        end
        if (eval_hit) r_parent[r_v_d] <= r_u;
        if (found)    r_nf <= nf;
        if (i_cmd.pop) begin
            r_u <= r_q_node[r_head[NODE_W-1:0]];
            r_f <= r_q_bn[r_head[NODE_W-1:0]];
        end
        if (i_cmd.issue) r_v_d <= r_v;
        if (i_cmd.aug_start)   r_cur <= dst_idx;
        else if (i_cmd.aug_w2) r_cur <= r_par;
        if (i_cmd.aug_rd) r_par <= cur_parent;
        if (i_cmd.load_out) r_out_total <= r_sum;
    end

    // search and result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_v         <= '0;
            r_eval      <= 1'b0;
            r_clr       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_eval <= i_cmd.issue && !found;
            if (i_cmd.clear_wr) r_clr <= r_clr + 1'b1;
            if (i_cmd.bfs_init) begin
                r_visited          <= '0;
                r_visited[src_idx] <= 1'b1;
                r_head             <= '0;
                r_tail             <= CNT_W'(1);
            end else begin
                if (eval_hit) r_visited[r_v_d] <= 1'b1;
                if (eval_hit && !found && (32'(r_tail) < MAX_NODES)) begin
                    r_tail <= r_tail + 1'b1;
                end
                if (i_cmd.pop) r_head <= r_head + 1'b1;
            end
            if (i_cmd.pop)        r_v <= '0;
            else if (i_cmd.issue) r_v <= r_v + 1'b1;
            // saturating total
            if (i_cmd.clear_wr) begin
                r_sum <= '0;
            end else if (i_cmd.aug_start) begin
                r_sum <= (sum_ext > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                       : mfek_pkg::TOTAL_W'(sum_ext);
            end
            if (i_cmd.load_out)      r_out_valid <= 1'b1;
            else if (o_result.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.total_flow = r_out_total;

    always_comb begin
        o_status             = '0;
        o_status.edge_last   = edge_take && i_edge.last_edge;
        o_status.bad_cfg     = bad_cfg;
        o_status.clear_done  = (r_clr == {ADDR_W{1'b1}});
        o_status.queue_empty = (r_head == r_tail);
        o_status.found       = found;
        o_status.scan_last   = (CNT_W'(r_v) == (n_live - 1'b1));
        o_status.at_src      = (r_cur == src_idx);
        o_status.out_free    = out_free;
    end

    `MFEK_ASSERT(a_tail_bound, i_clk, i_rst_n, 32'(r_tail) <= MAX_NODES)
    `MFEK_ASSERT(a_head_le_tail, i_clk, i_rst_n, r_head <= r_tail)
    `MFEK_ASSERT(a_result_not_lost, i_clk, i_rst_n, i_cmd.load_out |-> out_free)
    `MFEK_ASSERT_NEVER(a_no_load_in_clear, i_clk, i_rst_n, i_cmd.clear_wr && edge_take)

endmodule

/* design/max_flow_edmonds_karp.sv */
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp
// maximum flow over a loaded directed graph by breadth-first augmenting paths
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_edge     in   valid/ready    from_node, to_node, edge_capacity, last_edge
//  o_result   out  valid/ready    total_flow
//  i_cfg_*    in   write enable   register index, write data
//
//  edge transactions are taken one per cycle while loading
//  after the last edge the sequencer runs the search, skipped on a bad config:
//  each bfs pass scans all live nodes for each dequeued node, one read of the
//  capacity/flow memories per neighbour; an augment updates forward and
//  reverse flow on each hop; after reset and after every result a clearing
//  pass writes zero to all (MAX_NODES rounded up to a power of two)^2 memory
//  entries, 256 by default, while no edge is taken
//  a result waits in the output register; the next graph may load meanwhile
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp #(
    parameter int MAX_NODES = mfek_pkg::MAX_NODES_DEF,
    parameter int CAP_WIDTH = mfek_pkg::CAP_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mfek_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfek_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    mfek_edge_if.sink                       i_edge,
    mfek_flow_if.source                     o_result
);

    // command and status between sequencer and datapath
    mfek_pkg::t_cmd    cmd;
    mfek_pkg::t_status status;

    mfek_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // memories, queue, parent links and the result register
    mfek_dp #(
        .MAX_NODES (MAX_NODES),
        .CAP_WIDTH (CAP_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (i_edge),
        .o_result   (o_result),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule
